// ----- design/arx_pkg.sv -----
// Types and step functions of the ARX block permutation.
// Holds the 512-bit state type, the rotation constants and the column mix helpers.
// Depends on nothing; used by arx_block_permutation.
package arx_pkg;

  // Sixteen 32-bit words; word k sits at bits [32k+31:32k].
  typedef logic [15:0][31:0] state_t;

  // Left rotation amounts of rows b, c and d for one mix step.
  typedef struct packed {
    logic [4:0] b;
    logic [4:0] c;
    logic [4:0] d;
  } rot_t;

  localparam rot_t ROT_STEP0 = '{b: 5'd1, c: 5'd2,  d: 5'd3};
  localparam rot_t ROT_STEP1 = '{b: 5'd4, c: 5'd8,  d: 5'd12};
  localparam rot_t ROT_STEP2 = '{b: 5'd8, c: 5'd12, d: 5'd16};

  localparam logic ROT_LEFT  = 1'b1;
  localparam logic ROT_RIGHT = 1'b0;

  function automatic logic [31:0] rotl32(logic [31:0] x, logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] rotr32(logic [31:0] x, logic [4:0] n);
    logic [63:0] t;
    t = {x, x} >> n;
    return t[31:0];
  endfunction

  function automatic state_t xor_rc(state_t s, logic [31:0] rc);
    state_t t;
    t = s;
    t[0] = t[0] ^ rc;
    return t;
  endfunction

  function automatic state_t col_mix(state_t s);
    state_t t;
    t = s;
    for (int i = 0; i < 4; i++) begin
      t[i]      = t[i] + t[4 + i];
      t[8 + i]  = t[8 + i] + t[12 + i];
      t[4 + i]  = t[4 + i] ^ t[8 + i];
      t[12 + i] = t[12 + i] ^ t[i];
    end
    return t;
  endfunction

  function automatic state_t col_unmix(state_t s);
    state_t t;
    t = s;
    for (int i = 0; i < 4; i++) begin
      t[12 + i] = t[12 + i] ^ t[i];
      t[4 + i]  = t[4 + i] ^ t[8 + i];
      t[8 + i]  = t[8 + i] - t[12 + i];
      t[i]      = t[i] - t[4 + i];
    end
    return t;
  endfunction

  function automatic state_t rot_rows(state_t s, rot_t r, logic left);
    state_t t;
    t = s;
    for (int i = 0; i < 4; i++) begin
      if (left) begin
        t[4 + i]  = rotl32(s[4 + i], r.b);
        t[8 + i]  = rotl32(s[8 + i], r.c);
        t[12 + i] = rotl32(s[12 + i], r.d);
      end else begin
        t[4 + i]  = rotr32(s[4 + i], r.b);
        t[8 + i]  = rotr32(s[8 + i], r.c);
        t[12 + i] = rotr32(s[12 + i], r.d);
      end
    end
    return t;
  endfunction

  // Fixed lane shuffles of rows b, c and d; each one undoes itself.
  function automatic state_t lane_shuffle(state_t s);
    state_t t;
    t = s;
    t[5]  = s[7];
    t[7]  = s[5];
    t[8]  = s[9];
    t[9]  = s[8];
    t[10] = s[11];
    t[11] = s[10];
    t[12] = s[14];
    t[14] = s[12];
    return t;
  endfunction

endpackage

// ----- design/arx_block_permutation.sv -----
// Top level of the ARX block permutation: a pipeline of three stages per round.
// Uses arx_pkg for the state type and the mix, rotation and shuffle functions.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------------------
//   input   | in        | in_valid_i / in_stall_o  | mode_i, in_pair_0_i..in_pair_7_i
//   output  | out       | out_valid_o / out_stall_i| out_pair_0_o..out_pair_7_o
//
// One item enters per cycle while the input is not stalled, and each item passes
// through all stages of the ROUND_COUNT rounds (twelve by default) in order.
// Every round takes three register stages, one per column mix step, so each
// stage holds two 32-bit adds or subtracts per column and the rotations around it.
// Reset clears the valid bits of all stages and the skid register; the data
// registers are not reset.
// A stalled result moves into a skid register so the pipeline keeps its items;
// while the skid register is full the whole pipeline holds and the input stalls.
module arx_block_permutation #(
  parameter int ROUND_COUNT = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [63:0] in_pair_0_i,
  input  logic [63:0] in_pair_1_i,
  input  logic [63:0] in_pair_2_i,
  input  logic [63:0] in_pair_3_i,
  input  logic [63:0] in_pair_4_i,
  input  logic [63:0] in_pair_5_i,
  input  logic [63:0] in_pair_6_i,
  input  logic [63:0] in_pair_7_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_pair_0_o,
  output logic [63:0] out_pair_1_o,
  output logic [63:0] out_pair_2_o,
  output logic [63:0] out_pair_3_o,
  output logic [63:0] out_pair_4_o,
  output logic [63:0] out_pair_5_o,
  output logic [63:0] out_pair_6_o,
  output logic [63:0] out_pair_7_o
);

  import arx_pkg::*;

  localparam int NUM_STAGES = 3 * ROUND_COUNT;

  // Word 2k is the low half of pair k, so the pairs concatenate straight
  // into the packed state.
  state_t in_state;
  assign in_state = {in_pair_7_i, in_pair_6_i, in_pair_5_i, in_pair_4_i,
                     in_pair_3_i, in_pair_2_i, in_pair_1_i, in_pair_0_i};

  // Pipeline registers. The mode bit travels with each item, so forward and
  // inverse items can follow each other in any order.
  state_t st_q   [NUM_STAGES];
  logic   vld_q  [NUM_STAGES];
  logic   mode_q [NUM_STAGES];

  // Skid register that catches the last stage when the output is stalled.
  state_t skid_q;
  logic   skid_v_q, skid_v_d;
  logic   adv;

  // The pipeline moves as one whenever the skid register is empty.
  assign adv        = !skid_v_q;
  assign in_stall_o = skid_v_q;

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    localparam int RoundIdx = k / 3;
    localparam int Phase    = k % 3;
    // Forward round numbers count up from one along the pipeline; the inverse
    // runs them from ROUND_COUNT down.
    localparam int RFwd = RoundIdx + 1;
    localparam int RInv = ROUND_COUNT - RoundIdx;

    state_t s_in, fwd, inv, st_d;
    logic   m_in, v_in;

    if (k == 0) begin : g_first
      assign s_in = in_state;
      assign m_in = mode_i;
      assign v_in = in_valid_i;
    end else begin : g_next
      assign s_in = st_q[k-1];
      assign m_in = mode_q[k-1];
      assign v_in = vld_q[k-1];
    end

    // Forward: round constant (first step only), mix, rotate; the last step ends
    // with the shuffle. Inverse: the same steps undone in reverse order.
    if (Phase == 0) begin : g_step0
      assign fwd = rot_rows(col_mix(xor_rc(s_in, 32'(RFwd))), ROT_STEP0, ROT_LEFT);
      assign inv = col_unmix(rot_rows(lane_shuffle(s_in), ROT_STEP2, ROT_RIGHT));
    end else if (Phase == 1) begin : g_step1
      assign fwd = rot_rows(col_mix(s_in), ROT_STEP1, ROT_LEFT);
      assign inv = col_unmix(rot_rows(s_in, ROT_STEP1, ROT_RIGHT));
    end else begin : g_step2
      assign fwd = lane_shuffle(rot_rows(col_mix(s_in), ROT_STEP2, ROT_LEFT));
      assign inv = xor_rc(col_unmix(rot_rows(s_in, ROT_STEP0, ROT_RIGHT)), 32'(RInv));
    end

    assign st_d = m_in ? inv : fwd;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (adv) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[k]   <= st_d;
        mode_q[k] <= m_in;
      end
    end
  end

  // The skid register fills when a finished item meets a stalled output and
  // drains as soon as the output takes it. The item in it is always older
  // than the one that then sits in the last stage.
  always_comb begin
    skid_v_d = skid_v_q;
    if (skid_v_q) begin
      if (!out_stall_i) begin
        skid_v_d = 1'b0;
      end
    end else if (vld_q[NUM_STAGES-1] && out_stall_i) begin
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q && vld_q[NUM_STAGES-1] && out_stall_i) begin
      skid_q <= st_q[NUM_STAGES-1];
    end
  end

  state_t out_state;
  assign out_state   = skid_v_q ? skid_q : st_q[NUM_STAGES-1];
  assign out_valid_o = skid_v_q || vld_q[NUM_STAGES-1];

  assign out_pair_0_o = {out_state[1],  out_state[0]};
  assign out_pair_1_o = {out_state[3],  out_state[2]};
  assign out_pair_2_o = {out_state[5],  out_state[4]};
  assign out_pair_3_o = {out_state[7],  out_state[6]};
  assign out_pair_4_o = {out_state[9],  out_state[8]};
  assign out_pair_5_o = {out_state[11], out_state[10]};
  assign out_pair_6_o = {out_state[13], out_state[12]};
  assign out_pair_7_o = {out_state[15], out_state[14]};

endmodule

// ----- design/arx_chk.sv -----
// Port-level checker for arx_block_permutation, attached by the bind below.
// Depends only on the top level's port names.
module arx_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] out_pair_0_o
);

  // A stalled result stays and keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_pair_0_o))
    else $error("stalled result changed or vanished");

  // The input only stalls while a result waits at the output.
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  // The input stall starts only after the output was stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without an output stall");

  // Once the output takes the waiting item, the input is free again.
  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("input stall held after the output drained");

endmodule

bind arx_block_permutation arx_chk u_arx_chk (.*);
